### rtl/csc_pkg.sv
// Shared types and constants for the call argument-setup scanner.
// No dependencies; used by csc_decode and call_argument_setup_scanner_core.
package csc_pkg;

    localparam logic [7:0] REX_W       = 8'h48;
    localparam logic [7:0] REX_WR      = 8'h4C;
    localparam logic [7:0] OP_MOV      = 8'h8B;
    localparam logic [7:0] OP_LEA      = 8'h8D;
    localparam logic [7:0] OP_STORE    = 8'h89;
    localparam logic [7:0] OP_XOR      = 8'h33;
    localparam logic [7:0] OP_MOV_IMM  = 8'hC7;
    localparam logic [7:0] MODRM_DISP8 = 8'h44;
    localparam logic [7:0] MODRM_MASK  = 8'hC7;
    localparam logic [7:0] SIB_RSP     = 8'h24;
    localparam logic [7:0] CALL_OP     = 8'hE8;

    localparam logic [3:0] STACK_FIRST_IDX = 4'd5;
    localparam logic [3:0] REG_ARG_COUNT   = 4'd4;
    localparam logic [8:0] COUNT_MAX       = 9'd511;
    localparam logic [9:0] BUDGET_RESET    = 10'd256;
    localparam logic [3:0] FULL_VIEW       = 4'd8;

    // Register numbers, REX.R in bit 3
    localparam logic [3:0] REG_RCX = 4'd1;
    localparam logic [3:0] REG_RDX = 4'd2;
    localparam logic [3:0] REG_R8  = 4'd8;
    localparam logic [3:0] REG_R9  = 4'd9;

    typedef logic [7:0][7:0] view_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] len_m1;
        logic [3:0] reg_bits;
        logic       stack_ok;
        logic [3:0] stack_idx;
    } dec_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FLUSH,
        S_DONE
    } scan_state_t;

endpackage

### rtl/call_argument_setup_scanner_core.sv
// Call argument-setup scanner: byte sequencer, lookahead shift line and
// scan state around the shared csc_decode unit. Depends on csc_pkg, csc_decode.
// Throughput: one byte per cycle for bytes not marked last.
// A last byte is followed by a flush through the shared decoder and then the result state,
// which waits while an earlier result is not yet taken; no byte is accepted until idle again.
// Reset (rst_n, async, active low) clears the scan state and sets the budget to 256.
module call_argument_setup_scanner_core
#(
    parameter int WINDOW_BYTES = 512
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       budget_we,
    input  logic [9:0] budget_wdata,
    input  logic       code_valid,
    output logic       code_ready,
    input  logic [7:0] code_byte,
    input  logic       last_byte,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [3:0] reg_arg_mask,
    output logic [3:0] highest_stack_arg,
    output logic [8:0] patterns_matched,
    output logic [3:0] inferred_arg_count
);

    localparam int POS_W = $clog2(WINDOW_BYTES + 1);

    csc_pkg::scan_state_t state_reg, state_next;
    csc_pkg::view_t       win_reg, win_next;
    csc_pkg::view_t       view;
    csc_pkg::dec_t        dec;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]       skip_reg, skip_next;
    logic [3:0]       mask_reg, mask_next;
    logic [3:0]       stack_reg, stack_next;
    logic [8:0]       count_reg, count_next;
    logic             stopped_reg, stopped_next;
    logic [9:0]       budget_reg, budget_next;
    logic [2:0]       fcnt_reg, fcnt_next;
    logic [2:0]       fstart_reg, fstart_next;
    logic             rvalid_reg, rvalid_next;
    logic [3:0]       rmask_reg, rmask_next;
    logic [3:0]       rstack_reg, rstack_next;
    logic [8:0]       rcount_reg, rcount_next;
    logic [3:0]       rinfer_reg, rinfer_next;

    logic       in_fire;
    logic       in_window;
    logic       step_en;
    logic [3:0] avail;
    logic [2:0] pop;
    logic [3:0] pop_adj;

    csc_decode u_decode
    (
        .view  (view),
        .avail (avail),
        .dec   (dec)
    );

    assign code_ready         = (state_reg == csc_pkg::S_IDLE);
    assign in_fire            = code_valid && code_ready;
    assign in_window          = (pos_reg < POS_W'(WINDOW_BYTES));
    assign result_valid       = rvalid_reg;
    assign reg_arg_mask       = rmask_reg;
    assign highest_stack_arg  = rstack_reg;
    assign patterns_matched   = rcount_reg;
    assign inferred_arg_count = rinfer_reg;

    always_comb
    begin
        state_next   = state_reg;
        win_next     = win_reg;
        pos_next     = pos_reg;
        skip_next    = skip_reg;
        mask_next    = mask_reg;
        stack_next   = stack_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        budget_next  = budget_we ? budget_wdata : budget_reg;
        fcnt_next    = fcnt_reg;
        fstart_next  = fstart_reg;
        rvalid_next  = rvalid_reg && !result_ready;
        rmask_next   = rmask_reg;
        rstack_next  = rstack_reg;
        rcount_next  = rcount_reg;
        rinfer_next  = rinfer_reg;
        step_en      = 1'b0;
        view         = win_reg;
        avail        = csc_pkg::FULL_VIEW;

        pop = 3'(mask_reg[0]) + 3'(mask_reg[1]) + 3'(mask_reg[2]) + 3'(mask_reg[3]);
        pop_adj = {1'b0, pop};
        if (stack_reg >= csc_pkg::STACK_FIRST_IDX && pop_adj < csc_pkg::REG_ARG_COUNT)
        begin
            pop_adj = csc_pkg::REG_ARG_COUNT;
        end

        unique case (state_reg)
            csc_pkg::S_IDLE:
            begin
                view = {code_byte, win_reg[7:1]};
                if (in_fire)
                begin
                    if (in_window)
                    begin
                        win_next = {code_byte, win_reg[7:1]};
                        pos_next = pos_reg + POS_W'(1);
                        step_en  = !last_byte && (pos_reg >= POS_W'(7));
                    end
                    if (last_byte)
                    begin
                        state_next  = csc_pkg::S_FLUSH;
                        fcnt_next   = 3'd0;
                        fstart_next = (in_window && pos_reg < POS_W'(7)) ?
                                      (3'd7 - pos_reg[2:0]) : 3'd0;
                    end
                end
            end
            csc_pkg::S_FLUSH:
            begin
                avail     = csc_pkg::FULL_VIEW - {1'b0, fcnt_reg};
                step_en   = (fcnt_reg >= fstart_reg);
                win_next  = {csc_pkg::CALL_OP, win_reg[7:1]};
                fcnt_next = fcnt_reg + 3'd1;
                if (fcnt_reg == 3'd7)
                begin
                    state_next = csc_pkg::S_DONE;
                end
            end
            csc_pkg::S_DONE:
            begin
                if (!rvalid_reg || result_ready)
                begin
                    rvalid_next  = 1'b1;
                    rmask_next   = mask_reg;
                    rstack_next  = stack_reg;
                    rcount_next  = count_reg;
                    rinfer_next  = (pop_adj > stack_reg) ? pop_adj : stack_reg;
                    pos_next     = '0;
                    skip_next    = 3'd0;
                    mask_next    = 4'd0;
                    stack_next   = 4'd0;
                    count_next   = 9'd0;
                    stopped_next = 1'b0;
                    state_next   = csc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = csc_pkg::S_IDLE;
            end
        endcase

        // Apply one decision of the shared decoder
        if (step_en && !stopped_reg)
        begin
            priority if (skip_reg != 3'd0)
            begin
                skip_next = skip_reg - 3'd1;
            end
            else if (dec.hit)
            begin
                if (count_reg < csc_pkg::COUNT_MAX)
                begin
                    count_next = count_reg + 9'd1;
                end
                skip_next = dec.len_m1;
                mask_next = mask_reg | dec.reg_bits;
                if (dec.stack_ok && dec.stack_idx > stack_reg)
                begin
                    stack_next = dec.stack_idx;
                end
            end
            else if (budget_reg != 10'd0 && {1'b0, count_reg} >= budget_reg)
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                stopped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= csc_pkg::S_IDLE;
            pos_reg     <= '0;
            skip_reg    <= 3'd0;
            mask_reg    <= 4'd0;
            stack_reg   <= 4'd0;
            count_reg   <= 9'd0;
            stopped_reg <= 1'b0;
            budget_reg  <= csc_pkg::BUDGET_RESET;
            fcnt_reg    <= 3'd0;
            fstart_reg  <= 3'd0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            skip_reg    <= skip_next;
            mask_reg    <= mask_next;
            stack_reg   <= stack_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
            budget_reg  <= budget_next;
            fcnt_reg    <= fcnt_next;
            fstart_reg  <= fstart_next;
            rvalid_reg  <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg    <= win_next;
        rmask_reg  <= rmask_next;
        rstack_reg <= rstack_next;
        rcount_reg <= rcount_next;
        rinfer_reg <= rinfer_next;
    end

    a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg && state_reg != csc_pkg::S_DONE |=> stopped_reg)
        else $error("scan stop flag dropped inside a window");

    a_skip_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg != 3'd0 |-> count_reg != 9'd0)
        else $error("skip pending without any matched pattern");

    a_stack_range: assert property (@(posedge clk) disable iff (!rst_n)
        stack_reg == 4'd0 || stack_reg >= csc_pkg::STACK_FIRST_IDX)
        else $error("stack high outside the stack argument range");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(WINDOW_BYTES))
        else $error("window position past the window size");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rvalid_reg) |-> $past(state_reg) == csc_pkg::S_DONE)
        else $error("result raised outside the result cycle");

endmodule

### rtl/csc_decode.sv
// Pattern decoder: matches the four argument-setup forms at the front of an
// eight-byte view. Depends on csc_pkg.
module csc_decode
(
    input  csc_pkg::view_t view,
    input  logic [3:0]     avail,
    output csc_pkg::dec_t  dec
);

    logic       rex_ok;
    logic [3:0] reg_num;
    logic [3:0] reg_bits;
    logic [7:0] disp;
    logic       disp_ok;

    always_comb
    begin
        rex_ok  = (view[0] == csc_pkg::REX_W) || (view[0] == csc_pkg::REX_WR);
        reg_num = {view[0][2], view[2][5:3]};
        unique case (reg_num)
            csc_pkg::REG_RCX: reg_bits = 4'b0001;
            csc_pkg::REG_RDX: reg_bits = 4'b0010;
            csc_pkg::REG_R8:  reg_bits = 4'b0100;
            csc_pkg::REG_R9:  reg_bits = 4'b1000;
            default:          reg_bits = 4'b0000;
        endcase
        disp    = view[4];
        disp_ok = !disp[7] && (disp[2:0] == 3'd0) && (disp[6:3] >= csc_pkg::STACK_FIRST_IDX);

        dec           = '0;
        dec.stack_idx = disp[6:3];
        priority if (avail >= 4'd3 && rex_ok &&
                     (view[1] == csc_pkg::OP_MOV || view[1] == csc_pkg::OP_LEA))
        begin
            dec.hit      = 1'b1;
            dec.len_m1   = 3'd2;
            dec.reg_bits = reg_bits;
        end
        else if (avail >= 4'd5 && rex_ok && view[1] == csc_pkg::OP_STORE &&
                 (view[2] & csc_pkg::MODRM_MASK) == csc_pkg::MODRM_DISP8 &&
                 view[3] == csc_pkg::SIB_RSP)
        begin
            dec.hit      = 1'b1;
            dec.len_m1   = 3'd4;
            dec.stack_ok = disp_ok;
        end
        else if (avail == csc_pkg::FULL_VIEW && view[0] == csc_pkg::REX_W &&
                 view[1] == csc_pkg::OP_MOV_IMM && view[2] == csc_pkg::MODRM_DISP8 &&
                 view[3] == csc_pkg::SIB_RSP)
        begin
            dec.hit      = 1'b1;
            dec.len_m1   = 3'd7;
            dec.stack_ok = disp_ok;
        end
        else if (avail >= 4'd2 && rex_ok && view[1] == csc_pkg::OP_XOR)
        begin
            dec.hit      = 1'b1;
            dec.len_m1   = 3'd2;
            dec.reg_bits = reg_bits;
        end
        else
        begin
            dec.hit = 1'b0;
        end
    end

endmodule
